>>> hw/rtl/isplr_pkg.sv
// Shared constants, types and the command format for the score-line parser and ranker.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package isplr_pkg;

  // Table size and field widths.
  localparam int MAX_CANDIDATES = 32;
  localparam int SLOT_W  = $clog2(MAX_CANDIDATES);
  localparam int CNT_W   = $clog2(MAX_CANDIDATES + 1);
  localparam int ACC_W   = $clog2(MAX_CANDIDATES + 2);
  localparam int MUL_W   = ACC_W + 4;
  localparam int CFG_W   = 6;
  localparam int POS_W   = 5;
  localparam int SCORE_W = 3;
  localparam int TOT_W   = 6;
  localparam int BYTE_W  = 8;

  // Character codes and score limits.
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;
  localparam logic [3:0]        DEC_BASE   = 4'd10;
  localparam logic [3:0]        SCORE_MIN  = 4'd1;
  localparam logic [3:0]        SCORE_MAX  = 4'd5;
  localparam logic [CFG_W-1:0]  CFG_RESET  = 6'd32;

  // Depth of the command queue between parser and ranker.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One command from the parser: an optional score write and an optional ranking run.
  typedef struct packed {
    logic               wr;
    logic [SLOT_W-1:0]  slot;
    logic [SCORE_W-1:0] score;
    logic               rank;
    logic [CNT_W-1:0]   count;
  } cmd_t;

endpackage

>>> hw/rtl/isplr_front.sv
// Parser front end: holds the count register and the per-line state, turns bytes into commands.
// Depends on isplr_pkg.
`timescale 1ns / 1ps
module isplr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [isplr_pkg::CFG_W-1:0] cfg_candidate_count,
  input  logic                       in_push,
  input  logic [isplr_pkg::BYTE_W-1:0] in_text_byte,
  input  logic                       in_end_of_text,
  output logic                       in_full,
  input  logic                       q_full,
  output logic                       q_push,
  output isplr_pkg::cmd_t            q_cmd
);
  import isplr_pkg::*;

  typedef enum logic [3:0] {
    PH_SEEK_INDEX = 4'b0001,
    PH_READ_INDEX = 4'b0010,
    PH_SEEK_SCORE = 4'b0100,
    PH_LINE_DONE  = 4'b1000
  } phase_t;

  logic [CFG_W-1:0] cfg_r;
  phase_t           phase_r, phase_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  logic             accept;
  logic             is_digit;
  logic [3:0]       digit;
  logic [CNT_W-1:0] n_act;
  logic [MUL_W-1:0] acc_mul;
  logic             idx_ok;
  logic [3:0]       score_clamped;
  cmd_t             cmd;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Byte classification and the active candidate count.
  always_comb begin
    is_digit = (in_text_byte >= CHAR_ZERO) && (in_text_byte <= CHAR_NINE);
    digit    = is_digit ? 4'(in_text_byte - CHAR_ZERO) : 4'd0;
    n_act    = (32'(cfg_r) > MAX_CANDIDATES) ? CNT_W'(MAX_CANDIDATES) : CNT_W'(cfg_r);
    acc_mul  = MUL_W'(acc_r) * MUL_W'(DEC_BASE) + MUL_W'(digit);
    idx_ok   = (acc_r != '0) && (32'(acc_r) <= 32'(n_act));
    if (digit < SCORE_MIN) begin
      score_clamped = SCORE_MIN;
    end else if (digit > SCORE_MAX) begin
      score_clamped = SCORE_MAX;
    end else begin
      score_clamped = digit;
    end
  end

  // Line parser: next phase, accumulator and the command for this byte.
  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    cmd.wr      = 1'b0;
    cmd.slot    = SLOT_W'(acc_r - ACC_W'(1));
    cmd.score   = SCORE_W'(score_clamped);
    cmd.rank    = in_end_of_text;
    cmd.count   = n_act;
    if (in_text_byte == CHAR_NL) begin
      phase_nxt = PH_SEEK_INDEX;
      acc_nxt   = '0;
    end else begin
      unique case (phase_r)
        PH_SEEK_INDEX: begin
          if (is_digit) begin
            acc_nxt   = ACC_W'(digit);
            phase_nxt = PH_READ_INDEX;
          end
        end
        PH_READ_INDEX: begin
          if (is_digit) begin
            if (32'(acc_mul) > MAX_CANDIDATES) begin
              acc_nxt = ACC_W'(MAX_CANDIDATES + 1);
            end else begin
              acc_nxt = ACC_W'(acc_mul);
            end
          end else if (idx_ok) begin
            phase_nxt = PH_SEEK_SCORE;
          end else begin
            phase_nxt = PH_LINE_DONE;
          end
        end
        PH_SEEK_SCORE: begin
          if (is_digit) begin
            cmd.wr    = 1'b1;
            phase_nxt = PH_LINE_DONE;
          end
        end
        PH_LINE_DONE: begin
        end
        default: begin
          phase_nxt = PH_SEEK_INDEX;
        end
      endcase
    end
    // End of text starts the next text from a clean line.
    if (in_end_of_text) begin
      phase_nxt = PH_SEEK_INDEX;
      acc_nxt   = '0;
    end
  end

  assign q_push = accept && (cmd.wr || cmd.rank);
  assign q_cmd  = cmd;

  // Count register and parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= CFG_RESET;
      phase_r <= PH_SEEK_INDEX;
      acc_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_candidate_count;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

endmodule

>>> hw/rtl/isplr_queue.sv
// Short command queue between the parser and the ranker.
// Depends on isplr_pkg.
`timescale 1ns / 1ps
module isplr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  isplr_pkg::cmd_t din,
  output logic            full,
  input  logic            pop,
  output isplr_pkg::cmd_t dout,
  output logic            empty
);
  import isplr_pkg::*;

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r;
  logic [Q_PTR_W-1:0] rp_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (32'(cnt_r) == Q_DEPTH);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (32'(wp_r) == Q_DEPTH - 1) ? '0 : wp_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= (32'(rp_r) == Q_DEPTH - 1) ? '0 : rp_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/isplr_rank.sv
// Ranker back end: owns the score table, applies score writes and walks the table to rank.
// Depends on isplr_pkg.
`timescale 1ns / 1ps
module isplr_rank (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  isplr_pkg::cmd_t               q_cmd,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [isplr_pkg::POS_W-1:0]   out_candidate_position,
  output logic [isplr_pkg::SCORE_W-1:0] out_candidate_score,
  output logic [isplr_pkg::TOT_W-1:0]   out_scored_total,
  output logic                          out_last_of_run
);
  import isplr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t              state_r;
  logic [SCORE_W-1:0]  table_r [MAX_CANDIDATES];
  logic [MAX_CANDIDATES-1:0] valid_r;
  logic [CNT_W-1:0]    scored_r;
  logic [CNT_W-1:0]    n_r;
  logic [SLOT_W-1:0]   idx_r;
  logic [SCORE_W-1:0]  lvl_r;
  logic [CNT_W-1:0]    emit_r;

  logic                ov_r;
  logic [POS_W-1:0]    opos_r;
  logic [SCORE_W-1:0]  oscore_r;
  logic [TOT_W-1:0]    otot_r;
  logic                olast_r;

  logic                take;
  logic                adv;
  logic [SCORE_W-1:0]  cur_score;
  logic                hit;
  logic                row_end;

  assign take      = (state_r == ST_IDLE) && !q_empty;
  assign q_pop     = take;
  assign adv       = (state_r == ST_WALK) && (!ov_r || out_pop);
  assign cur_score = valid_r[idx_r] ? table_r[idx_r] : '0;
  assign hit       = (cur_score == lvl_r);
  assign row_end   = (idx_r == SLOT_W'(n_r - CNT_W'(1)));

  assign out_empty              = !ov_r;
  assign out_candidate_position = opos_r;
  assign out_candidate_score    = oscore_r;
  assign out_scored_total       = otot_r;
  assign out_last_of_run        = olast_r;

  // Score table data; unwritten or cleared entries read as zero through the valid bits.
  always_ff @(posedge clk) begin
    if (take && q_cmd.wr) begin
      table_r[q_cmd.slot] <= q_cmd.score;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (adv && hit) begin
      opos_r   <= POS_W'(idx_r);
      oscore_r <= cur_score;
      otot_r   <= TOT_W'(scored_r);
      olast_r  <= ({1'b0, emit_r} + (CNT_W + 1)'(1)) == {1'b0, n_r};
    end
  end

  // Control: command intake, table walk by descending score, output request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      scored_r <= '0;
      n_r      <= '0;
      idx_r    <= '0;
      lvl_r    <= '0;
      emit_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (out_pop && ov_r) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            if (q_cmd.wr) begin
              valid_r[q_cmd.slot] <= 1'b1;
              if (!valid_r[q_cmd.slot]) begin
                scored_r <= scored_r + CNT_W'(1);
              end
            end
            if (q_cmd.rank) begin
              if (q_cmd.count == '0) begin
                // Nothing to emit; the text ends here.
                valid_r  <= '0;
                scored_r <= '0;
              end else begin
                n_r     <= q_cmd.count;
                idx_r   <= '0;
                lvl_r   <= SCORE_W'(SCORE_MAX);
                emit_r  <= '0;
                state_r <= ST_WALK;
              end
            end
          end
        end
        ST_WALK: begin
          if (adv) begin
            if (hit) begin
              ov_r   <= 1'b1;
              emit_r <= emit_r + CNT_W'(1);
            end
            if (row_end) begin
              idx_r <= '0;
              if (lvl_r == '0) begin
                valid_r  <= '0;
                scored_r <= '0;
                state_r  <= ST_IDLE;
              end else begin
                lvl_r <= lvl_r - SCORE_W'(1);
              end
            end else begin
              idx_r <= idx_r + SLOT_W'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/index_score_line_parse_and_rank.sv
// Top level of the score-line parser and ranker: parser, command queue and ranker.
// Depends on isplr_pkg, isplr_front, isplr_queue and isplr_rank.
//
// Usage:
//   The input side is a queue: write one reply byte per cycle with in_push while in_full
//   is low; in_end_of_text marks the last byte of a reply. Every line gives at most one
//   score write, queued for the ranker. The configuration register cfg_candidate_count
//   (reset 32) must be written with cfg_wr_en only while idle; the block doesn't check.
//   The result side is a queue too: while out_empty is low a ranked candidate is on the
//   out_ ports, and out_pop takes it. Candidates come by descending score, ties by
//   position, and out_last_of_run marks the last one of a reply.
//   Throughput: one byte per cycle while parsing and in_full is low. After the
//   end-of-text byte the ranker takes the command, scans the table once per score level
//   and then clears the table through its valid bits. During that scan the two-entry
//   command queue can fill with later requests, and then in_full rises. When position
//   zero holds a score of 5, that candidate is the first result of the reply.
//   A stalled receiver holds the output register and pauses the scan; no result is lost.
//   Reset (synchronous, rst_n low) empties both queues, clears the table and line state.
`timescale 1ns / 1ps
module index_score_line_parse_and_rank (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [isplr_pkg::CFG_W-1:0]   cfg_candidate_count,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [isplr_pkg::BYTE_W-1:0]  in_text_byte,
  input  logic                          in_end_of_text,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [isplr_pkg::POS_W-1:0]   out_candidate_position,
  output logic [isplr_pkg::SCORE_W-1:0] out_candidate_score,
  output logic [isplr_pkg::TOT_W-1:0]   out_scored_total,
  output logic                          out_last_of_run
);
  import isplr_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_din;
  cmd_t q_dout;

  // Parser front end.
  isplr_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_candidate_count (cfg_candidate_count),
    .in_push             (in_push),
    .in_text_byte        (in_text_byte),
    .in_end_of_text      (in_end_of_text),
    .in_full             (in_full),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_cmd               (q_din)
  );

  // Command queue.
  isplr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // Ranker back end.
  isplr_rank u_rank (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_empty                (q_empty),
    .q_cmd                  (q_dout),
    .q_pop                  (q_pop),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_candidate_position (out_candidate_position),
    .out_candidate_score    (out_candidate_score),
    .out_scored_total       (out_scored_total),
    .out_last_of_run        (out_last_of_run)
  );

endmodule
